// File: src/nlgw_pkg.sv
// Package for the nonlinear guidance waypoint core.
// Holds the radius register format, the result case codes and the multiplier constants.
// No dependencies.
package nlgw_pkg;

  localparam int RADIUS_W = 20;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd2560;

  // Pipelined multiplier: operands are cut into chunks of this width.
  localparam int MUL_CHUNK = 24;
  localparam int MUL_LAT   = 4;

  typedef enum logic [1:0] {
    CASE_NEXT = 2'd0,
    CASE_PREV = 2'd1,
    CASE_VIRT = 2'd2
  } target_case_e;

endpackage

// File: src/nlgw_delay.sv
// Delay line with a shared advance enable, used to align side data with the pipeline.
// No dependencies.
module nlgw_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign d_o = tap_q[DEPTH-1];

endmodule

// File: src/nlgw_mul.sv
// Signed multiplier in four stages: magnitude, chunk products, accumulation, sign.
// Depends on nlgw_pkg for the chunk width.
module nlgw_mul
  import nlgw_pkg::*;
#(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  input  logic                 neg_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int K    = MUL_CHUNK;
  localparam int NA   = (WA + K - 1) / K;
  localparam int NB   = (WB + K - 1) / K;
  localparam int ACCW = (NA + NB) * K;
  localparam int PW   = WA + WB;

  logic [NA*K-1:0] ma_q, ma_d;
  logic [NB*K-1:0] mb_q, mb_d;
  logic [2:0]      sg_q;
  logic [2*K-1:0]  pp_q [NA][NB];
  logic [2*K-1:0]  pp_d [NA][NB];
  logic [PW-1:0]   sum_q, sum_d;
  logic [PW-1:0]   p_q, p_d;

  always_comb begin
    logic [WA-1:0] a_mag;
    logic [WB-1:0] b_mag;
    a_mag = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
    b_mag = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
    ma_d  = (NA*K)'(a_mag);
    mb_d  = (NB*K)'(b_mag);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = (2*K)'(ma_q[i*K +: K]) * (2*K)'(mb_q[j*K +: K]);
      end
    end
  end

  always_comb begin
    logic [ACCW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACCW'(pp_q[i][j]) << ((i + j) * K));
      end
    end
    sum_d = acc[PW-1:0];
  end

  assign p_d = sg_q[2] ? (~sum_q + 1'b1) : sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      sg_q  <= {sg_q[1:0], a_i[WA-1] ^ b_i[WB-1] ^ neg_i};
      pp_q  <= pp_d;
      sum_q <= sum_d;
      p_q   <= p_d;
    end
  end

  assign p_o = $signed(p_q);

endmodule

// File: src/nlgw_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor of the root).
// No dependencies.
module nlgw_sqrt #(
  parameter int SW = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SW-1:0]     x_i,
  output logic [SW/2-1:0]   root_o
);

  localparam int QW = SW / 2;
  localparam int RW = QW + 2;

  logic [SW-1:0] x_q  [QW];
  logic [SW-1:0] x_d  [QW];
  logic [RW-1:0] rm_q [QW];
  logic [RW-1:0] rm_d [QW];
  logic [QW-1:0] rt_q [QW];
  logic [QW-1:0] rt_d [QW];

  always_comb begin
    logic [SW-1:0] xi;
    logic [RW-1:0] ri, sh, tr;
    logic [QW-1:0] ti;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        xi = x_i;
        ri = '0;
        ti = '0;
      end else begin
        xi = x_q[k-1];
        ri = rm_q[k-1];
        ti = rt_q[k-1];
      end
      // The remainder never exceeds twice the partial root, so its top two bits are zero.
      sh      = {ri[RW-3:0], xi[SW-1 -: 2]};
      tr      = {ti, 2'b01};
      ge      = (sh >= tr);
      x_d[k]  = xi << 2;
      rm_d[k] = ge ? (sh - tr) : sh;
      rt_d[k] = {ti[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        x_q[k]  <= x_d[k];
        rm_q[k] <= rm_d[k];
        rt_q[k] <= rt_d[k];
      end
    end
  end

  assign root_o = rt_q[QW-1];

endmodule

// File: src/nlgw_div.sv
// Pipelined signed division by a positive divisor, rounded to nearest with ties away
// from zero. The quotient magnitude is known to fit QW bits. No dependencies.
module nlgw_div #(
  parameter int NW = 16,
  parameter int LU = 8,
  parameter int QW = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [LU-1:0]        den_i,
  output logic signed [QW+1:0] quo_o
);

  localparam int NMW = LU + QW;
  localparam int NS  = QW + 1;

  logic [LU-1:0] rm_q [NS];
  logic [LU-1:0] rm_d [NS];
  logic [QW-1:0] lo_q [NS];
  logic [QW-1:0] lo_d [NS];
  logic [QW-1:0] qt_q [NS];
  logic [QW-1:0] qt_d [NS];
  logic [LU-1:0] dn_q [NS];
  logic [LU-1:0] dn_d [NS];
  logic [NS-1:0] ng_q, ng_d;
  logic [QW+1:0] quo_q, quo_d;

  always_comb begin
    logic [NW-1:0]  mag_full;
    logic [NMW-1:0] mag;
    logic [LU:0]    t;
    logic           ge;
    mag_full = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    mag      = mag_full[NMW-1:0];
    // The bits above the quotient range give zero quotient bits, so they seed the remainder.
    rm_d[0] = mag[NMW-1:QW];
    lo_d[0] = mag[QW-1:0];
    qt_d[0] = '0;
    dn_d[0] = den_i;
    ng_d[0] = num_i[NW-1];
    for (int k = 1; k < NS; k++) begin
      t       = {rm_q[k-1], lo_q[k-1][QW-1]};
      ge      = (t >= {1'b0, dn_q[k-1]});
      rm_d[k] = ge ? LU'(t - {1'b0, dn_q[k-1]}) : LU'(t);
      lo_d[k] = lo_q[k-1] << 1;
      qt_d[k] = {qt_q[k-1][QW-2:0], ge};
      dn_d[k] = dn_q[k-1];
      ng_d[k] = ng_q[k-1];
    end
  end

  always_comb begin
    logic          up;
    logic [QW:0]   qm;
    up    = ({rm_q[NS-1], 1'b0} >= {1'b0, dn_q[NS-1]});
    qm    = {1'b0, qt_q[NS-1]} + (QW+1)'(up);
    quo_d = ng_q[NS-1] ? (QW+2)'(-{1'b0, qm}) : {1'b0, qm};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rm_q[k] <= rm_d[k];
        lo_q[k] <= lo_d[k];
        qt_q[k] <= qt_d[k];
        dn_q[k] <= dn_d[k];
      end
      ng_q  <= ng_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = $signed(quo_q);

endmodule

// File: src/nonlinear_guidance_waypoint_core.sv
// Top level of the nonlinear guidance waypoint core: look-ahead circle target point.
// Depends on nlgw_pkg, nlgw_delay, nlgw_mul, nlgw_sqrt and nlgw_div.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   prev_*, next_*, pos_* (x, y)
//   out      output     out_valid_o / out_ready_i target_x, target_y, target_case
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (look-ahead radius)
//
// One item enters per cycle while the output is not stalled; the one-bit-per-stage square root
// and the divider stages make up most of the pipeline.
// Reset clears the valid bits and loads the radius with 2560.
// A stall at the output freezes every stage together; the input is refused meanwhile.
module nonlinear_guidance_waypoint_core
  import nlgw_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] prev_x_i,
  input  logic signed [COORD_WIDTH-1:0] prev_y_i,
  input  logic signed [COORD_WIDTH-1:0] next_x_i,
  input  logic signed [COORD_WIDTH-1:0] next_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] target_x_o,
  output logic signed [COORD_WIDTH-1:0] target_y_o,
  output logic [1:0]                    target_case_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [RADIUS_W-1:0]           cfg_data_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int EW   = 2 * DW + 1;
  localparam int RSW  = RADIUS_W + 1;
  localparam int R2W  = 2 * RSW;
  localparam int GW   = (EW > R2W) ? EW : R2W;
  localparam int C2W  = 2 * EW;
  localparam int LIMW = R2W + EW;
  localparam int XW   = (C2W > LIMW) ? C2W : LIMW;
  localparam int SW   = 2 * CW + 42;
  localparam int QSW  = SW / 2;
  localparam int QSIW = QSW + 1;
  localparam int M3A  = QSIW + DW;
  localparam int M3B  = EW + DW;
  localparam int NW   = ((M3A > M3B) ? M3A : M3B) + 1;
  localparam int LU   = 2 * CW + 1;
  localparam int OFW  = RADIUS_W + 2;
  localparam int AW   = ((CW > OFW) ? CW : OFW) + 1;
  localparam int DL   = RADIUS_W + 2;
  localparam int LAT  = 17 + QSW + DL;
  localparam int BW   = 2 * CW + 2;

  localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  logic              en;
  logic [LAT-1:0]    vld_q;
  logic [RADIUS_W-1:0] radius_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      vld_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_data_i;
      end
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
    end
  end

  // Stage 1: differences.
  logic signed [DW-1:0]  dnx_q, dny_q, wx_q, wy_q, px_q, py_q;
  logic signed [RSW-1:0] r_q;
  logic [6*CW-1:0]       pts_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dnx_q <= DW'(next_x_i) - DW'(pos_x_i);
      dny_q <= DW'(next_y_i) - DW'(pos_y_i);
      wx_q  <= DW'(next_x_i) - DW'(prev_x_i);
      wy_q  <= DW'(next_y_i) - DW'(prev_y_i);
      px_q  <= DW'(pos_x_i) - DW'(prev_x_i);
      py_q  <= DW'(pos_y_i) - DW'(prev_y_i);
      r_q   <= $signed({1'b0, radius_q});
      pts_q <= {prev_x_i, prev_y_i, next_x_i, next_y_i, pos_x_i, pos_y_i};
    end
  end

  // Products of the differences and the square of the radius.
  logic signed [PW-1:0]  m_dnx2, m_dny2, m_wx2, m_wy2, m_pxwy, m_pywx, m_pxwx, m_pywy;
  logic signed [R2W-1:0] m_r2;

  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_dnx (.clk_i, .en_i(en), .a_i(dnx_q), .b_i(dnx_q),
                                          .neg_i(1'b0), .p_o(m_dnx2));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_dny (.clk_i, .en_i(en), .a_i(dny_q), .b_i(dny_q),
                                          .neg_i(1'b0), .p_o(m_dny2));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_wx (.clk_i, .en_i(en), .a_i(wx_q), .b_i(wx_q),
                                         .neg_i(1'b0), .p_o(m_wx2));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_wy (.clk_i, .en_i(en), .a_i(wy_q), .b_i(wy_q),
                                         .neg_i(1'b0), .p_o(m_wy2));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_pxwy (.clk_i, .en_i(en), .a_i(px_q), .b_i(wy_q),
                                           .neg_i(1'b0), .p_o(m_pxwy));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_pywx (.clk_i, .en_i(en), .a_i(py_q), .b_i(wx_q),
                                           .neg_i(1'b0), .p_o(m_pywx));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_pxwx (.clk_i, .en_i(en), .a_i(px_q), .b_i(wx_q),
                                           .neg_i(1'b0), .p_o(m_pxwx));
  nlgw_mul #(.WA(DW), .WB(DW)) u_mul_pywy (.clk_i, .en_i(en), .a_i(py_q), .b_i(wy_q),
                                           .neg_i(1'b0), .p_o(m_pywy));
  nlgw_mul #(.WA(RSW), .WB(RSW)) u_mul_r (.clk_i, .en_i(en), .a_i(r_q), .b_i(r_q),
                                          .neg_i(1'b0), .p_o(m_r2));

  logic [2*DW-1:0] w_s1;
  logic [2*DW-1:0] w_s10;
  logic [6*CW-1:0] pts_s10;

  assign w_s1 = {wx_q, wy_q};

  nlgw_delay #(.WIDTH(6*CW), .DEPTH(9)) u_dly_pts (.clk_i, .en_i(en), .d_i(pts_q),
                                                   .d_o(pts_s10));
  nlgw_delay #(.WIDTH(2*DW), .DEPTH(10+QSW)) u_dly_w (.clk_i, .en_i(en), .d_i(w_s1),
                                                      .d_o(w_s10));

  // Stage 6: sums of squares, cross and dot products, inside test.
  logic signed [EW-1:0]  l2_q, cr_q, dt_q;
  logic signed [R2W-1:0] r2_q;
  logic                  inside_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q     <= EW'(m_wx2) + EW'(m_wy2);
      cr_q     <= EW'(m_pxwy) - EW'(m_pywx);
      dt_q     <= EW'(m_pxwx) + EW'(m_pywy);
      r2_q     <= m_r2;
      inside_q <= (GW'(EW'(m_dnx2) + EW'(m_dny2)) < GW'(m_r2));
    end
  end

  logic signed [C2W-1:0]  m_c2;
  logic signed [LIMW-1:0] m_lim;

  nlgw_mul #(.WA(EW), .WB(EW)) u_mul_c2 (.clk_i, .en_i(en), .a_i(cr_q), .b_i(cr_q),
                                         .neg_i(1'b0), .p_o(m_c2));
  nlgw_mul #(.WA(R2W), .WB(EW)) u_mul_lim (.clk_i, .en_i(en), .a_i(r2_q), .b_i(l2_q),
                                           .neg_i(1'b0), .p_o(m_lim));

  logic [2*EW:0]        s6_bus, s10_bus;
  logic [EW-1:0]        cr_s11;
  logic signed [EW-1:0] l2_s10, dt_s10;
  logic                 inside_s10;

  assign s6_bus = {l2_q, dt_q, inside_q};

  nlgw_delay #(.WIDTH(2*EW+1), .DEPTH(MUL_LAT)) u_dly_s6 (.clk_i, .en_i(en), .d_i(s6_bus),
                                                         .d_o(s10_bus));
  nlgw_delay #(.WIDTH(EW), .DEPTH(5+QSW)) u_dly_cr (.clk_i, .en_i(en), .d_i(cr_q),
                                                    .d_o(cr_s11));

  assign l2_s10     = $signed(s10_bus[2*EW -: EW]);
  assign dt_s10     = $signed(s10_bus[EW -: EW]);
  assign inside_s10 = s10_bus[0];

  // Stage 11: case decision, base point and the square-root operand.
  logic [SW-1:0]  rad_q;
  logic           fwd_q;
  logic [BW-1:0]  base_q;
  logic [EW-1:0]  l2h_q;

  always_ff @(posedge clk_i) begin
    logic signed [XW-1:0] c2x, limx, diff;
    target_case_e         tc;
    logic [CW-1:0]        bx, by;
    c2x  = XW'(m_c2);
    limx = XW'(m_lim);
    diff = limx - c2x;
    if (inside_s10) begin
      tc = CASE_NEXT;
      bx = pts_s10[3*CW +: CW];
      by = pts_s10[2*CW +: CW];
    end else if ((l2_s10 == '0) || (c2x > limx)) begin
      tc = CASE_PREV;
      bx = pts_s10[5*CW +: CW];
      by = pts_s10[4*CW +: CW];
    end else begin
      tc = CASE_VIRT;
      bx = pts_s10[CW +: CW];
      by = pts_s10[0 +: CW];
    end
    if (en) begin
      rad_q  <= (tc == CASE_VIRT) ? diff[SW-1:0] : '0;
      fwd_q  <= (dt_s10 < l2_s10);
      base_q <= {bx, by, tc};
      l2h_q  <= l2_s10;
    end
  end

  logic [QSW-1:0] q_root;

  nlgw_sqrt #(.SW(SW)) u_sqrt (.clk_i, .en_i(en), .x_i(rad_q), .root_o(q_root));

  logic          fwd_sq;
  logic [BW-1:0] base_fin;
  logic [EW-1:0] l2_div;

  nlgw_delay #(.WIDTH(1), .DEPTH(QSW)) u_dly_fwd (.clk_i, .en_i(en), .d_i(fwd_q),
                                                  .d_o(fwd_sq));
  nlgw_delay #(.WIDTH(BW), .DEPTH(5+QSW+DL)) u_dly_base (.clk_i, .en_i(en), .d_i(base_q),
                                                        .d_o(base_fin));
  nlgw_delay #(.WIDTH(EW), .DEPTH(5+QSW)) u_dly_l2 (.clk_i, .en_i(en), .d_i(l2h_q),
                                                   .d_o(l2_div));

  logic signed [QSIW-1:0] q_s;
  logic signed [DW-1:0]   wx_s, wy_s;
  logic signed [EW-1:0]   cr_s;
  logic signed [M3A-1:0]  m_qwx, m_qwy;
  logic signed [M3B-1:0]  m_crwx, m_crwy;

  assign q_s  = $signed({1'b0, q_root});
  assign wx_s = $signed(w_s10[2*DW-1 -: DW]);
  assign wy_s = $signed(w_s10[DW-1:0]);
  assign cr_s = $signed(cr_s11);

  // The root takes the sign of the chosen direction through the multiplier's sign input.
  nlgw_mul #(.WA(QSIW), .WB(DW)) u_mul_qwx (.clk_i, .en_i(en), .a_i(q_s), .b_i(wx_s),
                                            .neg_i(!fwd_sq), .p_o(m_qwx));
  nlgw_mul #(.WA(QSIW), .WB(DW)) u_mul_qwy (.clk_i, .en_i(en), .a_i(q_s), .b_i(wy_s),
                                            .neg_i(!fwd_sq), .p_o(m_qwy));
  nlgw_mul #(.WA(EW), .WB(DW)) u_mul_crwx (.clk_i, .en_i(en), .a_i(cr_s), .b_i(wx_s),
                                           .neg_i(1'b0), .p_o(m_crwx));
  nlgw_mul #(.WA(EW), .WB(DW)) u_mul_crwy (.clk_i, .en_i(en), .a_i(cr_s), .b_i(wy_s),
                                           .neg_i(1'b0), .p_o(m_crwy));

  logic signed [NW-1:0] numx_q, numy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q <= NW'(m_qwx) - NW'(m_crwy);
      numy_q <= NW'(m_crwx) + NW'(m_qwy);
    end
  end

  logic signed [OFW-1:0] off_x, off_y;

  nlgw_div #(.NW(NW), .LU(LU), .QW(RADIUS_W)) u_div_x (.clk_i, .en_i(en), .num_i(numx_q),
                                                      .den_i(l2_div[LU-1:0]), .quo_o(off_x));
  nlgw_div #(.NW(NW), .LU(LU), .QW(RADIUS_W)) u_div_y (.clk_i, .en_i(en), .num_i(numy_q),
                                                      .den_i(l2_div[LU-1:0]), .quo_o(off_y));

  // Output stage: add the offset for a virtual point and saturate.
  logic signed [CW-1:0] tx_q, ty_q;
  logic [1:0]           tc_q;

  always_ff @(posedge clk_i) begin
    logic signed [AW-1:0] sx, sy;
    logic signed [CW-1:0] bx, by;
    target_case_e         tc;
    bx = $signed(base_fin[CW+2 +: CW]);
    by = $signed(base_fin[2 +: CW]);
    tc = target_case_e'(base_fin[1:0]);
    sx = AW'(bx) + AW'(off_x);
    sy = AW'(by) + AW'(off_y);
    if (en) begin
      if (tc == CASE_VIRT) begin
        tx_q <= (sx > SAT_HI) ? CW'(SAT_HI) : ((sx < SAT_LO) ? CW'(SAT_LO) : CW'(sx));
        ty_q <= (sy > SAT_HI) ? CW'(SAT_HI) : ((sy < SAT_LO) ? CW'(SAT_LO) : CW'(sy));
      end else begin
        tx_q <= bx;
        ty_q <= by;
      end
      tc_q <= tc;
    end
  end

  assign out_valid_o   = vld_q[LAT-1];
  assign target_x_o    = tx_q;
  assign target_y_o    = ty_q;
  assign target_case_o = tc_q;

endmodule

// File: src/nlgw_checker.sv
// Port-level checks for the nonlinear guidance waypoint core, bound to its top level.
// No dependencies.
module nlgw_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [COORD_WIDTH-1:0] target_x_o,
  input logic signed [COORD_WIDTH-1:0] target_y_o,
  input logic [1:0]                    target_case_o
);

  // A refused result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_x_o)
      && $stable(target_y_o) && $stable(target_case_o))
    else $error("result changed while stalled");

  // The whole pipeline freezes while a result waits, so no new item may enter.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted during output stall");

  // With the output register empty the pipeline must be able to move.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output");

endmodule

bind nonlinear_guidance_waypoint_core nlgw_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (.*);
